// ----- sv/phps_pkg.sv -----
// phps_pkg: shared types and constants for the pid heater power step block
// controller commands, datapath status, configuration bundle and state codes
// no dependencies
`default_nettype none

package phps_pkg;

    // stream payload layout
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 16;

    // field widths
    localparam int TEMP_W    = 9;
    localparam int READING_W = 14;
    localparam int MS_W      = 12;
    localparam int POWER_W   = 12;
    localparam int GAIN_W    = 10;
    localparam int SCALE_W   = 4;
    localparam int ERR_W     = 12;
    localparam int ISUM_W    = 18;

    // field offsets inside the input tdata
    localparam int TARGET_LSB  = 0;
    localparam int READING_LSB = TARGET_LSB + TEMP_W;
    localparam int MS_LSB      = READING_LSB + READING_W;
    localparam int LIMIT_LSB   = MS_LSB + MS_W;

    // x / 10 = (x * 52429) >> 19, exact for |x| <= 8192
    localparam logic [15:0] RECIP_TEN       = 16'd52429;
    localparam int          RECIP_TEN_SHIFT = 19;
    // x / 100 = (x * 167773) >> 24, exact for x < 2**17
    localparam logic [17:0] RECIP_HUNDRED       = 18'd167773;
    localparam int          RECIP_HUNDRED_SHIFT = 24;
    // x / 1000 = ((x >> 3) * 1099511628) >> 37, exact for x < 2**33
    localparam int          RECIP_THOUSAND_PRE   = 3;
    localparam logic [30:0] RECIP_THOUSAND       = 31'd1099511628;
    localparam int          RECIP_THOUSAND_SHIFT = 37;

    // serial divider for the derivative term, two quotient bits per cycle
    localparam int DIV_W      = 22;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_CYCLES = DIV_W / DIV_STEPS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

    // register reset values
    localparam logic [GAIN_W-1:0]  GAIN_P_RST    = 10'd8;
    localparam logic [GAIN_W-1:0]  GAIN_I_RST    = 10'd2;
    localparam logic [GAIN_W-1:0]  GAIN_D_RST    = 10'd0;
    localparam logic [SCALE_W-1:0] SCALE_RST     = 4'd5;
    localparam logic [TEMP_W-1:0]  MIN_TEMP_RST  = 9'd10;

    typedef enum logic [2:0] {
        REG_GAIN_P   = 3'd0,
        REG_GAIN_I   = 3'd1,
        REG_GAIN_D   = 3'd2,
        REG_SCALE    = 3'd3,
        REG_MIN_TEMP = 3'd4
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_ERR,
        S_MUL,
        S_MUL2,
        S_DDIV,
        S_IMUL,
        S_ILATCH,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_d;
        logic [SCALE_W-1:0] scale;
        logic [TEMP_W-1:0]  min_temp;
    } cfg_t;

    typedef struct packed {
        logic load_in;
        logic prep;
        logic calc_err;
        logic mul;
        logic start_ddiv;
        logic latch_d;
        logic imul;
        logic latch_i;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

// ----- sv/phps_div.sv -----
// phps_div: unsigned serial divider, two quotient bits per cycle
// restoring shift-subtract, fixed run length; uses phps_pkg
`default_nettype none

module phps_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [phps_pkg::DIV_W-1:0]   dividend,
    input  wire logic [phps_pkg::MS_W-1:0]    divisor,
    output logic                              done,
    output logic [phps_pkg::DIV_W-1:0]        quotient
);
    import phps_pkg::*;

    logic [MS_W-1:0]      rem_reg,  rem_next;
    logic [DIV_W-1:0]     quo_reg,  quo_next;
    logic [MS_W-1:0]      dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    always_comb
    begin
        logic [MS_W:0] trial;
        rem_next = rem_reg;
        quo_next = quo_reg;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            trial    = {rem_next, quo_next[DIV_W-1]};
            quo_next = {quo_next[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next    = MS_W'(trial - {1'b0, dvs_reg});
                quo_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[MS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == DIV_CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_CYCLES);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- sv/phps_datapath.sv -----
// phps_datapath: error, pid terms, anti-windup integration and output register
// driven by phps_ctrl commands; instantiates phps_div; uses phps_pkg
`default_nettype none

module phps_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire phps_pkg::cfg_t                  cfg,
    input  wire phps_pkg::cmd_t                  cmd,
    output phps_pkg::stat_t                      stat,
    input  wire logic [phps_pkg::IN_DATA_W-1:0]  in_data,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [phps_pkg::OUT_DATA_W-1:0]      out_data
);
    import phps_pkg::*;

    // captured request
    logic [TEMP_W-1:0]           target_reg;
    logic signed [READING_W-1:0] reading_reg;
    logic [MS_W-1:0]             interval_reg;
    logic [POWER_W-1:0]          limit_reg;

    // pipeline of the step
    logic                 rd_neg_reg;
    logic [29:0]          rd_prod_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic signed [21:0]   pterm_reg;
    logic                 d_neg_reg;
    logic [21:0]          d_mag_reg;
    logic signed [23:0]   ei_reg;
    logic                 i_neg_reg;
    logic [34:0]          i_prod_reg;
    logic [15:0]          bound_reg;
    logic signed [10:0]   iterm_reg;
    logic                 e_neg_reg;
    logic [32:0]          eig_mag_reg;
    logic [59:0]          iq_prod_reg;
    logic signed [24:0]   outv_reg;
    logic signed [23:0]   delta_reg;

    // controller state
    logic signed [ERR_W-1:0]  last_err_reg,  last_err_next;
    logic signed [ISUM_W-1:0] isum_reg,      isum_next;
    logic                     out_valid_reg;
    logic [POWER_W-1:0]       drive_reg,     drive_next;

    // divider
    logic               div_start;
    logic [DIV_W-1:0]   div_dividend;
    logic [MS_W-1:0]    div_divisor;
    logic               div_done;
    logic [DIV_W-1:0]   div_quo;

    // combinational terms
    logic [READING_W-1:0]   rd_mag;
    logic [10:0]            rd_q;
    logic signed [10:0]     reading_q;
    logic signed [ERR_W-1:0] err_calc;
    logic signed [22:0]     p_full;
    logic signed [12:0]     err_diff;
    logic signed [23:0]     d_full;
    logic [23:0]            d_abs;
    logic signed [24:0]     ei_full;
    logic [ISUM_W-1:0]      isum_abs;
    logic [10:0]            i_q;
    logic signed [34:0]     eig_full;
    logic [34:0]            eig_abs;
    logic [22:0]            eig_q;
    logic signed [22:0]     dterm;
    logic signed [23:0]     delta_calc;
    logic signed [24:0]     limit_s;
    logic signed [24:0]     bound_s;
    logic signed [24:0]     sum_calc;
    logic                   sat_hi;
    logic                   sat_lo;

    assign rd_mag    = reading_reg[READING_W-1] ? READING_W'(-reading_reg)
                                                : READING_W'(reading_reg);
    assign rd_q      = rd_prod_reg[29:RECIP_TEN_SHIFT];
    assign reading_q = rd_neg_reg ? -$signed(rd_q) : $signed(rd_q);
    assign err_calc  = $signed({3'b000, target_reg}) - ERR_W'(reading_q);

    assign p_full   = $signed({1'b0, cfg.gain_p}) * err_reg;
    assign err_diff = 13'(err_reg) - 13'(last_err_reg);
    assign d_full   = $signed({1'b0, cfg.gain_d}) * err_diff;
    assign d_abs    = d_full[23] ? 24'(-d_full) : 24'(d_full);
    assign ei_full  = err_reg * $signed({1'b0, interval_reg});
    assign isum_abs = isum_reg[ISUM_W-1] ? ISUM_W'(-isum_reg) : ISUM_W'(isum_reg);

    assign i_q      = i_prod_reg[34:RECIP_HUNDRED_SHIFT];
    assign eig_full = ei_reg * $signed({1'b0, cfg.gain_i});
    assign eig_abs  = eig_full[34] ? 35'(-eig_full) : 35'(eig_full);
    assign eig_q    = iq_prod_reg[59:RECIP_THOUSAND_SHIFT];

    assign dterm      = d_neg_reg ? -$signed({1'b0, div_quo})
                                  : $signed({1'b0, div_quo});
    assign delta_calc = e_neg_reg ? -$signed({1'b0, eig_q})
                                  : $signed({1'b0, eig_q});

    // divider runs only the derivative over the interval
    assign div_start    = cmd.start_ddiv;
    assign div_dividend = d_mag_reg;
    assign div_divisor  = interval_reg;

    phps_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // anti-windup, integral clamp, output clamp and zero drive below min_temp
    always_comb
    begin
        limit_s = $signed({13'b0, limit_reg});
        bound_s = $signed({9'b0, bound_reg});
        sat_hi  = (outv_reg >= limit_s) && (err_reg > 0);
        sat_lo  = (outv_reg <= 0) && (err_reg < 0);
        sum_calc = 25'(isum_reg);
        if (!(sat_hi || sat_lo))
        begin
            sum_calc = sum_calc + 25'(delta_reg);
        end
        if (sum_calc > bound_s)
        begin
            sum_calc = bound_s;
        end
        else if (sum_calc < -bound_s)
        begin
            sum_calc = -bound_s;
        end
        isum_next     = sum_calc[ISUM_W-1:0];
        last_err_next = err_reg;

        if (outv_reg > limit_s)
        begin
            drive_next = limit_reg;
        end
        else if (outv_reg < 0)
        begin
            drive_next = '0;
        end
        else
        begin
            drive_next = outv_reg[POWER_W-1:0];
        end
        if (target_reg < cfg.min_temp)
        begin
            drive_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            target_reg   <= in_data[TARGET_LSB +: TEMP_W];
            reading_reg  <= $signed(in_data[READING_LSB +: READING_W]);
            interval_reg <= (in_data[MS_LSB +: MS_W] == '0) ? MS_W'(1)
                                                           : in_data[MS_LSB +: MS_W];
            limit_reg    <= in_data[LIMIT_LSB +: POWER_W];
        end
        if (cmd.prep)
        begin
            rd_neg_reg  <= reading_reg[READING_W-1];
            rd_prod_reg <= rd_mag * RECIP_TEN;
        end
        if (cmd.calc_err)
        begin
            err_reg <= err_calc;
        end
        if (cmd.mul)
        begin
            pterm_reg  <= p_full[21:0];
            d_neg_reg  <= d_full[23];
            d_mag_reg  <= d_abs[21:0];
            ei_reg     <= ei_full[23:0];
            i_neg_reg  <= isum_reg[ISUM_W-1];
            i_prod_reg <= isum_abs[16:0] * RECIP_HUNDRED;
            bound_reg  <= cfg.scale * limit_reg;
        end
        if (cmd.start_ddiv)
        begin
            iterm_reg   <= i_neg_reg ? -$signed(i_q) : $signed(i_q);
            e_neg_reg   <= eig_full[34];
            eig_mag_reg <= eig_abs[32:0];
        end
        if (cmd.latch_d)
        begin
            outv_reg <= 25'(pterm_reg) + 25'(iterm_reg) + 25'(dterm);
        end
        if (cmd.imul)
        begin
            iq_prod_reg <= eig_mag_reg[32:RECIP_THOUSAND_PRE] * RECIP_THOUSAND;
        end
        if (cmd.latch_i)
        begin
            delta_reg <= delta_calc;
        end
        if (cmd.out_load)
        begin
            drive_reg <= drive_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_err_reg  <= '0;
            isum_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.out_load)
            begin
                last_err_reg  <= last_err_next;
                isum_reg      <= isum_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.div_done = div_done;
    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_data      = OUT_DATA_W'(drive_reg);

endmodule

`default_nettype wire

// ----- sv/phps_ctrl.sv -----
// phps_ctrl: step sequencer for the pid heater power step
// issues datapath commands, waits on the divider and the output register; uses phps_pkg
`default_nettype none

module phps_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire phps_pkg::stat_t stat,
    output phps_pkg::cmd_t       cmd
);
    import phps_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_ERR;
            end
            S_ERR:
            begin
                cmd.calc_err = 1'b1;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.start_ddiv = 1'b1;
                state_next     = S_DDIV;
            end
            S_DDIV:
            begin
                if (stat.div_done)
                begin
                    cmd.latch_d = 1'b1;
                    state_next  = S_IMUL;
                end
            end
            S_IMUL:
            begin
                cmd.imul   = 1'b1;
                state_next = S_ILATCH;
            end
            S_ILATCH:
            begin
                cmd.latch_i = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                // state and result commit together once the output slot is free
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/pid_heater_power_step.sv -----
// pid heater power step: one drive request per accepted sample request
// steps: prep, error, multiply, divider start, a wait on the divider run for the
// derivative over the interval, integral multiply and latch, then the output load
// no new request is taken before the output load, which waits for a free slot;
// a finished result may wait in the output register while the next request is taken
// reset: gains, scale and min_temp to defaults, last error and integral sum to zero
`default_nettype none

module pid_heater_power_step (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // sample input
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // target_temp[8:0], reading_tenths[22:9], elapsed_ms[34:23], power_limit[46:35]
    input  wire logic [47:0] s_axis_tdata,
    // drive output
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // drive_power[11:0]
    output logic [15:0]      m_axis_tdata
);
    import phps_pkg::*;

    logic [GAIN_W-1:0]  gain_p_reg;
    logic [GAIN_W-1:0]  gain_i_reg;
    logic [GAIN_W-1:0]  gain_d_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [TEMP_W-1:0]  min_temp_reg;

    logic     cfg_wr;
    reg_idx_t cfg_idx;
    cfg_t     cfg;
    cmd_t     cmd;
    stat_t    stat;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg   <= GAIN_P_RST;
            gain_i_reg   <= GAIN_I_RST;
            gain_d_reg   <= GAIN_D_RST;
            scale_reg    <= SCALE_RST;
            min_temp_reg <= MIN_TEMP_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_GAIN_P:   gain_p_reg   <= pwdata[GAIN_W-1:0];
                REG_GAIN_I:   gain_i_reg   <= pwdata[GAIN_W-1:0];
                REG_GAIN_D:   gain_d_reg   <= pwdata[GAIN_W-1:0];
                REG_SCALE:    scale_reg    <= pwdata[SCALE_W-1:0];
                REG_MIN_TEMP: min_temp_reg <= pwdata[TEMP_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_GAIN_P:   prdata = 32'(gain_p_reg);
            REG_GAIN_I:   prdata = 32'(gain_i_reg);
            REG_GAIN_D:   prdata = 32'(gain_d_reg);
            REG_SCALE:    prdata = 32'(scale_reg);
            REG_MIN_TEMP: prdata = 32'(min_temp_reg);
            default:      prdata = '0;
        endcase
    end

    assign cfg.gain_p   = gain_p_reg;
    assign cfg.gain_i   = gain_i_reg;
    assign cfg.gain_d   = gain_d_reg;
    assign cfg.scale    = scale_reg;
    assign cfg.min_temp = min_temp_reg;

    phps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    phps_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ----- dv/pid_heater_power_step_tb.sv -----
// testbench for pid_heater_power_step: random and directed sample requests against a
// cycle-free drive predictor, APB register settings between phases, random stalls
// depends on phps_pkg and the pid_heater_power_step rtl
`default_nettype none

module pid_heater_power_step_tb;

    import phps_pkg::*;

    // tracks controller state and holds the drive values still owed by the block
    class drive_scoreboard;
        longint gain_p, gain_i, gain_d, isum_scale, min_temp;
        longint prev_err, isum;
        logic [POWER_W-1:0] drive_q[$];
        int errors;

        function new();
            gain_p     = GAIN_P_RST;
            gain_i     = GAIN_I_RST;
            gain_d     = GAIN_D_RST;
            isum_scale = SCALE_RST;
            min_temp   = MIN_TEMP_RST;
            prev_err   = 0;
            isum       = 0;
            errors     = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [31:0] val);
            case (idx)
                REG_GAIN_P:   gain_p = val[GAIN_W-1:0];
                REG_GAIN_I:   gain_i = val[GAIN_W-1:0];
                REG_GAIN_D:   gain_d = val[GAIN_W-1:0];
                REG_SCALE:    isum_scale = val[SCALE_W-1:0];
                REG_MIN_TEMP: min_temp = val[TEMP_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_request(logic [IN_DATA_W-1:0] req);
            logic signed [READING_W-1:0] raw;
            longint tgt, rd, ms, lim, err, drv, acc, bound;
            tgt = req[TARGET_LSB +: TEMP_W];
            raw = req[READING_LSB +: READING_W];
            rd  = raw;
            rd  = rd / 10;
            ms  = req[MS_LSB +: MS_W];
            lim = req[LIMIT_LSB +: POWER_W];
            if (ms == 0)
                ms = 1;
            err = tgt - rd;
            drv = gain_p * err + isum / 100 + (gain_d * (err - prev_err)) / ms;
            // no integration while pushing further into saturation
            acc = isum;
            if (!((drv >= lim && err > 0) || (drv <= 0 && err < 0)))
                acc = acc + (err * ms * gain_i) / 1000;
            bound = isum_scale * lim;
            if (acc > bound)
                acc = bound;
            else if (acc < -bound)
                acc = -bound;
            isum     = acc;
            prev_err = err;
            if (drv > lim)
                drv = lim;
            else if (drv < 0)
                drv = 0;
            if (tgt < min_temp)
                drv = 0;
            drive_q.push_back(drv[POWER_W-1:0]);
        endfunction

        function void check_drive(logic [OUT_DATA_W-1:0] got);
            logic [OUT_DATA_W-1:0] want;
            if (drive_q.size() == 0)
            begin
                errors++;
                $display("%0t: drive mismatch: expected none, actual %0d", $time, got);
            end
            else
            begin
                want = drive_q.pop_front();
                if (got !== want)
                begin
                    errors++;
                    $display("%0t: drive mismatch: expected %0d, actual %0d",
                             $time, want, got);
                end
            end
        endfunction
    endclass

    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 3000;
    localparam int DRAIN_CYCLES  = 60;
    localparam int PHASE_ITEMS   = 135;
    localparam int RANDOM_PHASES = 8;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [4:0]            paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  in_data;
    logic                  m_axis_tvalid;
    logic                  out_ready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    bit quiet;
    bit hold_req;
    int stall_cycles;

    drive_scoreboard sb = new();

    pid_heater_power_step DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (in_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (in_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (out_ready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
        clk = 1'b0;

    always #1 clk = ~clk;

    // request and result monitor plus stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && s_axis_tready)
                sb.note_request(in_data);
            if (m_axis_tvalid && out_ready)
                sb.check_drive(m_axis_tdata);
            if ((in_valid && s_axis_tready) || (m_axis_tvalid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // drive consumer: random stalls, one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 9)) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(0, 15)) @(negedge clk);
            end
        end
    end

    function automatic logic [IN_DATA_W-1:0] pack_req(int tgt, int rd, int ms, int lim);
        logic [IN_DATA_W-1:0] req;
        req = '0;
        req[TARGET_LSB +: TEMP_W]     = tgt[TEMP_W-1:0];
        req[READING_LSB +: READING_W] = rd[READING_W-1:0];
        req[MS_LSB +: MS_W]           = ms[MS_W-1:0];
        req[LIMIT_LSB +: POWER_W]     = lim[POWER_W-1:0];
        return req;
    endfunction

    function automatic int pick_edge(int a, int b, int c, int d);
        case ($urandom_range(0, 3))
            0: return a;
            1: return b;
            2: return c;
            default: return d;
        endcase
    endfunction

    // mostly plausible control loop samples, some raw noise and field extremes
    function automatic logic [IN_DATA_W-1:0] rand_request();
        int tgt, rd, ms, lim;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
            begin
                tgt = $urandom_range(0, 450);
                if ($urandom_range(0, 2) == 0)
                    rd = $urandom_range(0, 8591) - 400;
                else
                    rd = tgt * 10 + $urandom_range(0, 600) - 300;
                if (rd < -400)
                    rd = -400;
                ms  = $urandom_range(1, 250);
                lim = $urandom_range(50, 4095);
            end
            6, 7:
            begin
                tgt = $urandom();
                rd  = $urandom();
                ms  = $urandom();
                lim = $urandom();
            end
            8:
            begin
                tgt = pick_edge(0, 450, 511, $urandom_range(0, 511));
                rd  = pick_edge(-400, 8191, -8192, $urandom_range(0, 18) - 9);
                ms  = pick_edge(0, 1, 4095, $urandom_range(0, 4095));
                lim = pick_edge(0, 1, 4095, $urandom_range(0, 4095));
            end
            default:
            begin
                tgt = $urandom_range(0, 15);
                rd  = $urandom_range(0, 1000);
                ms  = $urandom_range(0, 300);
                lim = $urandom_range(0, 4095);
            end
        endcase
        return pack_req(tgt, rd, ms, lim);
    endfunction

    task automatic send_req(input logic [IN_DATA_W-1:0] req);
        int gap;
        gap = (quiet || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 10);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // stop offering and wait for every owed drive, then let the datapath settle
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.drive_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_reg(idx, val);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_all(input logic [31:0] gp, input logic [31:0] gi,
                             input logic [31:0] gd, input logic [31:0] scale,
                             input logic [31:0] tmin);
        write_reg(REG_GAIN_P, gp);
        write_reg(REG_GAIN_I, gi);
        write_reg(REG_GAIN_D, gd);
        write_reg(REG_SCALE, scale);
        write_reg(REG_MIN_TEMP, tmin);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        in_data      = '0;
        quiet        = 1'b0;
        hold_req     = 1'b0;
        stall_cycles = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset gains: saturation both ways, inactive set point, zero interval and limit
        send_req(pack_req(0, 0, 0, 0));
        send_req(pack_req(450, 200, 100, 4095));
        send_req(pack_req(450, 200, 100, 4095));
        send_req(pack_req(20, 8191, 4095, 4095));
        send_req(pack_req(511, -8192, 0, 4095));
        send_req(pack_req(5, 300, 50, 1000));
        send_req(pack_req(100, 1009, 20, 500));
        send_req(pack_req(100, -9, 1, 500));
        send_req(pack_req(100, 9, 10, 0));
        send_req(pack_req(300, 2995, 4095, 4095));
        send_req(pack_req(300, 3005, 0, 2000));
        send_req(pack_req(0, -400, 1, 1));
        drain();

        // largest gains: derivative over a zero interval, threshold set point
        write_all(1023, 1023, 1023, 15, 450);
        send_req(pack_req(450, 4500, 0, 4095));
        send_req(pack_req(450, 0, 0, 4095));
        send_req(pack_req(450, 8191, 0, 4095));
        send_req(pack_req(449, 4490, 100, 4095));
        send_req(pack_req(511, -400, 4095, 4095));
        send_req(pack_req(450, 4495, 1, 4095));
        send_req(pack_req(450, 4505, 1, 4095));
        send_req(pack_req(450, -8192, 0, 0));
        send_req(pack_req(450, 4500, 0, 1));
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: write_all(10, 5, 0, 5, 10);
                1: write_all(0, 0, 0, 0, 0);
                2: write_all(1023, 1023, 1023, 15, 450);
                3: write_all(40, 300, 50, 1, 0);
                4, 6: write_all($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
                5: write_all($urandom_range(0, 60), $urandom_range(0, 1023),
                             $urandom_range(0, 200), $urandom_range(1, 15),
                             $urandom_range(0, 50));
                default:
                begin
                    write_all(20, 100, 20, 15, 10);
                    quiet = 1'b1;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 3 && n == 30)
                    hold_req = 1'b1;
                send_req(rand_request());
            end
            drain();
        end

        if (sb.errors == 0 && sb.drive_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
sv/phps_pkg.sv
sv/phps_div.sv
sv/phps_datapath.sv
sv/phps_ctrl.sv
sv/pid_heater_power_step.sv
dv/pid_heater_power_step_tb.sv
